### hw/rtl/qrtt_pkg.sv
// ----------------------------------------------------------------------------
// qrtt_pkg
// Shared types, widths and register indexes for the quadrotor thrust model.
// ----------------------------------------------------------------------------
package qrtt_pkg;

    localparam int DUTY_W  = 18;
    localparam int DT_W    = 24;
    localparam int SPEED_W = 32;
    localparam int OUT_W   = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 64;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 66;
    localparam int DIVD_W  = 56;
    localparam int DIVS_W  = 25;
    localparam int ACC_W   = 52;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_UP    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_DOWN  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRUST_K   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_K     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROTOR_X    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROTOR_Y    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_DIR   = 4'd7;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = -ACC_W'(64'sd2147483648);
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

### hw/rtl/quad_rotor_thrust_torque_model_top.sv
// ----------------------------------------------------------------------------
// quad_rotor_thrust_torque_model_top
// Quadrotor first-order motor lag with body force and torque output.
//
// Input channel: four duties and a time step, taken when i_in_valid is high
// and o_in_stall is low. The block is stalled while one transaction is being
// worked on. Each rotor takes nine passes through one shared 33x33 multiplier
// and a 56-step restoring divide for the speed step.
// Output channel: force_z and three torques, held in an output register with
// o_out_valid until taken (i_out_stall low). A stalled result holds the
// block before its final load, so the next transaction waits behind it.
// Configuration channel: i_cfg_valid with o_cfg_ready always high, index and
// 64-bit data; indexes 8 and up are dropped. Write only while idle.
// Reset (i_rst_n low, synchronous) clears speeds, registers (time constants
// to 1) and the output valid flag.
// ----------------------------------------------------------------------------
module quad_rotor_thrust_torque_model_top #(
    parameter int ROTOR_COUNT = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [qrtt_pkg::DUTY_W-1:0]      i_duty_rotor0,
    input  logic signed [qrtt_pkg::DUTY_W-1:0]      i_duty_rotor1,
    input  logic signed [qrtt_pkg::DUTY_W-1:0]      i_duty_rotor2,
    input  logic signed [qrtt_pkg::DUTY_W-1:0]      i_duty_rotor3,
    input  logic [qrtt_pkg::DT_W-1:0]               i_time_step_us,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [qrtt_pkg::OUT_W-1:0]       o_force_z,
    output logic signed [qrtt_pkg::OUT_W-1:0]       o_torque_x,
    output logic signed [qrtt_pkg::OUT_W-1:0]       o_torque_y,
    output logic signed [qrtt_pkg::OUT_W-1:0]       o_torque_z,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [qrtt_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [qrtt_pkg::CFG_DAT_W-1:0]          i_cfg_data
);
    import qrtt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TGT    = 4'd1;
    localparam logic [3:0] S_DIFF   = 4'd2;
    localparam logic [3:0] S_DSTART = 4'd3;
    localparam logic [3:0] S_DWAIT  = 4'd4;
    localparam logic [3:0] S_W2     = 4'd5;
    localparam logic [3:0] S_T1     = 4'd6;
    localparam logic [3:0] S_T2     = 4'd7;
    localparam logic [3:0] S_R1     = 4'd8;
    localparam logic [3:0] S_R2     = 4'd9;
    localparam logic [3:0] S_OY     = 4'd10;
    localparam logic [3:0] S_OX     = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    localparam logic [1:0] LAST_IDX = 2'(ROTOR_COUNT - 1);

    logic [3:0]            r_state;
    logic [1:0]            r_idx;
    logic [SPEED_W-1:0]    r_speed [4];
    logic signed [DUTY_W-1:0] r_duty [4];
    logic [DT_W-1:0]       r_dt;

    logic [31:0]           r_max_speed;
    logic [23:0]           r_spin_up;
    logic [23:0]           r_spin_down;
    logic [31:0]           r_thrust_k;
    logic [31:0]           r_drag_k;
    logic [63:0]           r_rotor_x;
    logic [63:0]           r_rotor_y;
    logic [3:0]            r_spin_dir;

    logic [DIVS_W-1:0]     r_den;
    logic                  r_ge;
    logic [63:0]           r_w2;
    logic [31:0]           r_lo;
    logic [31:0]           r_thrust;
    logic signed [ACC_W-1:0] r_fz;
    logic signed [ACC_W-1:0] r_tz;
    logic signed [ACC_W-1:0] r_sy;
    logic signed [ACC_W-1:0] r_sx;

    logic                  r_out_valid;
    logic signed [OUT_W-1:0] r_force_z;
    logic signed [OUT_W-1:0] r_torque_x;
    logic signed [OUT_W-1:0] r_torque_y;
    logic signed [OUT_W-1:0] r_torque_z;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    logic [SPEED_W-1:0]       div_quot;
    t_div_stat                div_stat;

    logic signed [DUTY_W-1:0] duty_raw;
    logic [16:0]              duty_clamp;
    logic [SPEED_W-1:0]       cur_w;
    logic [SPEED_W-1:0]       target;
    logic [23:0]              tau_sel;
    logic [23:0]              tau_eff;
    logic [SPEED_W-1:0]       diff;
    logic [SPEED_W-1:0]       w_new;
    logic [63:0]              gain_sum;
    logic [15:0]              off_y;
    logic [15:0]              off_x;
    logic signed [ACC_W-1:0]  neg_sy;
    logic signed [ACC_W-1:0]  sh_x;
    logic signed [ACC_W-1:0]  sh_y;

    qrtt_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    qrtt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod[DIVD_W-1:0]),
        .i_divisor  (r_den),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    always_comb begin
        duty_raw = r_duty[r_idx];
        if (duty_raw < 0) begin
            duty_clamp = '0;
        end else if (duty_raw > 18'sd65536) begin
            duty_clamp = 17'd65536;
        end else begin
            duty_clamp = duty_raw[16:0];
        end
        cur_w    = r_speed[r_idx];
        target   = prod[47:16];
        tau_sel  = (target > cur_w) ? r_spin_up : r_spin_down;
        tau_eff  = (tau_sel == '0) ? 24'd1 : tau_sel;
        diff     = (target >= cur_w) ? (target - cur_w) : (cur_w - target);
        w_new    = r_ge ? (cur_w + div_quot) : (cur_w - div_quot);
        gain_sum = prod[63:0] + {32'd0, r_lo};
        off_y    = r_rotor_y[{r_idx, 4'd0} +: 16];
        off_x    = r_rotor_x[{r_idx, 4'd0} +: 16];
        neg_sy   = -r_sy;
        sh_x     = neg_sy >>> 12;
        sh_y     = r_sx >>> 12;
        div_start = (r_state == S_DSTART);

        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_TGT: begin
                mul_a = {16'd0, duty_clamp};
                mul_b = {1'b0, r_max_speed};
            end
            S_DIFF: begin
                mul_a = {1'b0, diff};
                mul_b = {9'd0, r_dt};
            end
            S_DWAIT: begin
                mul_a = {1'b0, w_new};
                mul_b = {1'b0, w_new};
            end
            S_W2: begin
                mul_a = {1'b0, prod[31:0]};
                mul_b = {1'b0, r_thrust_k};
            end
            S_T1: begin
                mul_a = {1'b0, r_w2[63:32]};
                mul_b = {1'b0, r_thrust_k};
            end
            S_T2: begin
                mul_a = {1'b0, r_w2[31:0]};
                mul_b = {1'b0, r_drag_k};
            end
            S_R1: begin
                mul_a = {1'b0, r_w2[63:32]};
                mul_b = {1'b0, r_drag_k};
            end
            S_R2: begin
                mul_a = {{17{off_y[15]}}, off_y};
                mul_b = {1'b0, r_thrust};
            end
            S_OY: begin
                mul_a = {{17{off_x[15]}}, off_x};
                mul_b = {1'b0, r_thrust};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= '0;
            r_spin_up   <= 24'd1;
            r_spin_down <= 24'd1;
            r_thrust_k  <= '0;
            r_drag_k    <= '0;
            r_rotor_x   <= '0;
            r_rotor_y   <= '0;
            r_spin_dir  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_SPEED: r_max_speed <= i_cfg_data[31:0];
                REG_SPIN_UP:   r_spin_up   <= i_cfg_data[23:0];
                REG_SPIN_DOWN: r_spin_down <= i_cfg_data[23:0];
                REG_THRUST_K:  r_thrust_k  <= i_cfg_data[31:0];
                REG_DRAG_K:    r_drag_k    <= i_cfg_data[31:0];
                REG_ROTOR_X:   r_rotor_x   <= i_cfg_data;
                REG_ROTOR_Y:   r_rotor_y   <= i_cfg_data;
                REG_SPIN_DIR:  r_spin_dir  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_speed[i] <= '0;
            end
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_duty[0] <= i_duty_rotor0;
                        r_duty[1] <= i_duty_rotor1;
                        r_duty[2] <= i_duty_rotor2;
                        r_duty[3] <= i_duty_rotor3;
                        r_dt      <= i_time_step_us;
                        r_idx     <= '0;
                        r_fz      <= '0;
                        r_tz      <= '0;
                        r_sy      <= '0;
                        r_sx      <= '0;
                        r_state   <= S_TGT;
                    end
                end
                S_TGT: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_den   <= {1'b0, tau_eff} + {1'b0, r_dt};
                    r_ge    <= (target >= cur_w);
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_stat.done) begin
                        r_speed[r_idx] <= w_new;
                        r_state        <= S_W2;
                    end
                end
                S_W2: begin
                    r_w2    <= prod[63:0];
                    r_state <= S_T1;
                end
                S_T1: begin
                    r_lo    <= prod[63:32];
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_thrust <= gain_sum[63:32];
                    r_fz     <= r_fz - ACC_W'(signed'({1'b0, gain_sum[63:32]}));
                    r_state  <= S_R1;
                end
                S_R1: begin
                    r_lo    <= prod[63:32];
                    r_state <= S_R2;
                end
                S_R2: begin
                    if (r_spin_dir[r_idx]) begin
                        r_tz <= r_tz + ACC_W'(signed'({1'b0, gain_sum[63:32]}));
                    end else begin
                        r_tz <= r_tz - ACC_W'(signed'({1'b0, gain_sum[63:32]}));
                    end
                    r_state <= S_OY;
                end
                S_OY: begin
                    r_sy    <= r_sy + prod[ACC_W-1:0];
                    r_state <= S_OX;
                end
                S_OX: begin
                    r_sx <= r_sx + prod[ACC_W-1:0];
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_TGT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_force_z   <= sat32(r_fz);
                        r_torque_x  <= sat32(sh_x);
                        r_torque_y  <= sat32(sh_y);
                        r_torque_z  <= sat32(r_tz);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_force_z   = r_force_z;
    assign o_torque_x  = r_torque_x;
    assign o_torque_y  = r_torque_y;
    assign o_torque_z  = r_torque_z;
    assign o_cfg_ready = 1'b1;

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside final load");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_idx <= LAST_IDX)
        else $error("rotor index beyond rotor count");

endmodule

### hw/rtl/qrtt_mul.sv
// ----------------------------------------------------------------------------
// qrtt_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module qrtt_mul (
    input  logic                                i_clk,
    input  logic signed [qrtt_pkg::MUL_W-1:0]   i_a,
    input  logic signed [qrtt_pkg::MUL_W-1:0]   i_b,
    output logic signed [qrtt_pkg::PROD_W-1:0]  o_prod
);
    import qrtt_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### hw/rtl/qrtt_div.sv
// ----------------------------------------------------------------------------
// qrtt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qrtt_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [qrtt_pkg::DIVD_W-1:0]     i_dividend,
    input  logic [qrtt_pkg::DIVS_W-1:0]     i_divisor,
    output logic [qrtt_pkg::SPEED_W-1:0]    o_quot,
    output qrtt_pkg::t_div_stat             o_stat
);
    import qrtt_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] r_quot;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_divs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVS_W:0]   n_shift;
    logic [DIVS_W:0]   n_diff;

    always_comb begin
        n_shift = {r_rem, r_quot[DIVD_W-1]};
        n_diff  = n_shift - {1'b0, r_divs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_divs <= i_divisor;
            end else if (r_busy) begin
                if (!n_diff[DIVS_W]) begin
                    r_rem <= n_diff[DIVS_W-1:0];
                end else begin
                    r_rem <= n_shift[DIVS_W-1:0];
                end
                r_quot <= {r_quot[DIVD_W-2:0], ~n_diff[DIVS_W]};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot      = r_quot[SPEED_W-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
